/* sv/wcx_pkg.sv */
// ----------------------------------------------------------------------------
// wcx_pkg: shared types and constants
// Word layouts for both channels, the job word passed from the front end to
// the back end, and the sizes of the hex tag expansion.
// ----------------------------------------------------------------------------
package wcx_pkg;

    localparam int BYTE_W          = 8;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Tag expansion layout: "[u]", eight hex digits, "[/u]"
    localparam int TAG_LEN       = 15;
    localparam int TAG_HEX_FIRST = 3;
    localparam int TAG_HEX_END   = 11;
    localparam int TAG_IDX_W     = 4;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_string;
    } in_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic              string_done;
    } out_word_t;

    // RAW: emit bytes[0..last_idx] unchanged; TAG: emit the hex tag of bytes
    typedef enum logic {
        JOB_RAW = 1'b0,
        JOB_TAG = 1'b1
    } job_kind_t;

    typedef struct packed {
        job_kind_t              kind;
        logic [1:0]             last_idx;
        logic                   eos;
        logic [3:0][BYTE_W-1:0] bytes;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

/* sv/wcx_regs.sv */
// ----------------------------------------------------------------------------
// wcx_regs: configuration registers
// APB-style register file holding the lead byte range.
// ----------------------------------------------------------------------------
module wcx_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wcx_pkg::PADDR_W-1:0]  paddr,
    input  logic [wcx_pkg::PDATA_W-1:0]  pwdata,
    output logic [wcx_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [wcx_pkg::BYTE_W-1:0]   lead_low,
    output logic [wcx_pkg::BYTE_W-1:0]   lead_high
);
    import wcx_pkg::*;

    localparam logic REG_LEAD_LOW  = 1'b0;
    localparam logic REG_LEAD_HIGH = 1'b1;
    localparam logic [BYTE_W-1:0] LEAD_LOW_RST  = 8'd239;
    localparam logic [BYTE_W-1:0] LEAD_HIGH_RST = 8'd246;

    logic [BYTE_W-1:0] lead_low_reg;
    logic [BYTE_W-1:0] lead_high_reg;
    logic              wr_en;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    // Write on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_low_reg  <= LEAD_LOW_RST;
            lead_high_reg <= LEAD_HIGH_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_LEAD_LOW:  lead_low_reg  <= pwdata[BYTE_W-1:0];
                REG_LEAD_HIGH: lead_high_reg <= pwdata[BYTE_W-1:0];
                default:       lead_low_reg  <= lead_low_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_LEAD_LOW:  prdata[BYTE_W-1:0] = lead_low_reg;
            REG_LEAD_HIGH: prdata[BYTE_W-1:0] = lead_high_reg;
            default:       prdata = '0;
        endcase
    end

    assign lead_low  = lead_low_reg;
    assign lead_high = lead_high_reg;

endmodule

/* sv/wcx_front.sv */
// ----------------------------------------------------------------------------
// wcx_front: input classifier
// Accepts input words, collects four-byte captures and queues one job for
// every input word that produces output.
// ----------------------------------------------------------------------------
module wcx_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  wcx_pkg::in_word_t           in_data,
    input  logic [wcx_pkg::BYTE_W-1:0]  lead_low,
    input  logic [wcx_pkg::BYTE_W-1:0]  lead_high,
    input  wcx_pkg::q_stat_t            q_stat,
    output logic                        push,
    output wcx_pkg::job_t               push_job
);
    import wcx_pkg::*;

    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic [BYTE_W-1:0] held_reg [3];
    logic              take;
    logic              is_lead;
    logic              hold;
    logic [BYTE_W-1:0] b;
    logic              eos;

    assign b        = in_data.in_byte;
    assign eos      = in_data.end_of_string;
    assign in_ready = !q_stat.full;
    assign take     = in_valid & in_ready;
    assign is_lead  = (b >= lead_low) && (b <= lead_high);

    // Keep the byte for a capture instead of producing output
    always_comb
    begin
        if (count_reg == 2'd0)
            hold = is_lead && !eos;
        else
            hold = (count_reg != 2'd3) && !eos;
    end

    assign push = take && !hold;

    // Held bytes first, current byte after them
    always_comb
    begin
        push_job.kind     = (count_reg == 2'd3) ? JOB_TAG : JOB_RAW;
        push_job.last_idx = count_reg;
        push_job.eos      = eos;
        push_job.bytes[0] = (count_reg > 2'd0) ? held_reg[0] : b;
        push_job.bytes[1] = (count_reg > 2'd1) ? held_reg[1] : b;
        push_job.bytes[2] = (count_reg > 2'd2) ? held_reg[2] : b;
        push_job.bytes[3] = b;
    end

    // Advance or drop the capture
    always_comb
    begin
        count_next = count_reg;
        if (take)
            count_next = hold ? count_reg + 2'd1 : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && hold)
            held_reg[count_reg] <= b;
    end

endmodule

/* sv/wcx_queue.sv */
// ----------------------------------------------------------------------------
// wcx_queue: job queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module wcx_queue #(
    parameter int DEPTH = wcx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wcx_pkg::job_t     push_job,
    input  logic              pop,
    output wcx_pkg::job_t     head_job,
    output wcx_pkg::q_stat_t  stat
);
    import wcx_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    assign stat.full  = (fill_reg == CNT_FULL);
    assign stat.empty = (fill_reg == '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

/* sv/wcx_back.sv */
// ----------------------------------------------------------------------------
// wcx_back: output sequencer
// Expands the job at the queue head into output words, one per cycle while
// out_ready lets the registered output stage take them.
// ----------------------------------------------------------------------------
module wcx_back (
    input  logic              clk,
    input  logic              rst_n,
    input  wcx_pkg::job_t     head_job,
    input  wcx_pkg::q_stat_t  q_stat,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output wcx_pkg::out_word_t out_data,
    output logic              busy
);
    import wcx_pkg::*;

    localparam logic [TAG_IDX_W-1:0] HEX_FIRST = TAG_IDX_W'(TAG_HEX_FIRST);
    localparam logic [TAG_IDX_W-1:0] HEX_END   = TAG_IDX_W'(TAG_HEX_END);
    localparam logic [TAG_IDX_W-1:0] TAG_LAST  = TAG_IDX_W'(TAG_LEN - 1);

    logic [TAG_IDX_W-1:0] idx_reg;
    logic [TAG_IDX_W-1:0] hex_pos;
    logic                 out_valid_reg;
    out_word_t            out_data_reg;
    logic                 load;
    logic                 step;
    logic                 is_last;
    logic [BYTE_W-1:0]    cur_byte;
    logic [BYTE_W-1:0]    src_byte;
    logic [3:0]           nibble;

    // Lower-case hex digit of a nibble
    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] v);
        hex_digit = (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
    endfunction

    // Fixed characters of "[u]" and "[/u]"
    function automatic logic [BYTE_W-1:0] tag_char(input logic [TAG_IDX_W-1:0] i);
        case (i)
            4'd0, 4'd11: tag_char = 8'h5b;
            4'd1, 4'd13: tag_char = 8'h75;
            4'd2, 4'd14: tag_char = 8'h5d;
            4'd12:       tag_char = 8'h2f;
            default:     tag_char = 8'h00;
        endcase
    endfunction

    assign load    = !out_valid_reg || out_ready;
    assign step    = load && !q_stat.empty;
    assign hex_pos = idx_reg - HEX_FIRST;
    assign src_byte = head_job.bytes[hex_pos[2:1]];
    assign nibble  = hex_pos[0] ? src_byte[3:0] : src_byte[7:4];

    // Pick the byte for the current position
    always_comb
    begin
        if (head_job.kind == JOB_TAG)
        begin
            is_last = (idx_reg == TAG_LAST);
            if (idx_reg >= HEX_FIRST && idx_reg < HEX_END)
                cur_byte = hex_digit(nibble);
            else
                cur_byte = tag_char(idx_reg);
        end
        else
        begin
            is_last  = (idx_reg[1:0] == head_job.last_idx);
            cur_byte = head_job.bytes[idx_reg[1:0]];
        end
    end

    assign pop = step && is_last;

    // Advance position; refill the output stage when it is free or taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                out_valid_reg <= !q_stat.empty;
            if (step)
                idx_reg <= is_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg.out_byte    <= cur_byte;
            out_data_reg.last_of_run <= is_last;
            out_data_reg.string_done <= is_last && head_job.eos;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign busy      = (idx_reg != '0);

endmodule

/* sv/wide_char_hex_tag_escaper_unit.sv */
// ----------------------------------------------------------------------------
// wide_char_hex_tag_escaper_unit: wide character hex tag escaper
// Byte stream filter that rewrites four-byte sequences opened by a lead byte
// as "[u]xxxxxxxx[/u]" and passes all other bytes through.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid/in_ready/in_data) carry one byte and an end of
//   string flag. Output words (out_valid/out_ready/out_data) carry one byte,
//   a flag on the last word produced by an input word, and a flag on the last
//   word of a string. The APB port sets the lead byte range (0x0 low, 0x4
//   high); pready is always high.
//   An accepted word's job is written into the job queue, and the back end
//   then loads its first output word into the output register.
//   The back end gives one output word per cycle while the receiver takes
//   them, so pass-through bytes flow at one per cycle; a completed capture
//   expands into 15 output words, and input continues to be accepted until
//   the QUEUE_DEPTH-entry job queue fills. Bytes that only extend a capture
//   queue no job and are accepted while the queue is not full.
//   Reset clears the capture, the queue and the output stage and loads the
//   lead range 239..246. A stalled receiver holds the output register; the
//   queue then fills and in_ready drops.
// ----------------------------------------------------------------------------
module wide_char_hex_tag_escaper_unit #(
    parameter int QUEUE_DEPTH = wcx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  wcx_pkg::in_word_t            in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output wcx_pkg::out_word_t           out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wcx_pkg::PADDR_W-1:0]  paddr,
    input  logic [wcx_pkg::PDATA_W-1:0]  pwdata,
    output logic [wcx_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import wcx_pkg::*;

    logic [BYTE_W-1:0] lead_low;
    logic [BYTE_W-1:0] lead_high;
    q_stat_t           q_stat;
    logic              push;
    job_t              push_job;
    logic              pop;
    job_t              head_job;
    logic              back_busy;

    wcx_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .lead_low  (lead_low),
        .lead_high (lead_high)
    );

    wcx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .lead_low  (lead_low),
        .lead_high (lead_high),
        .q_stat    (q_stat),
        .push      (push),
        .push_job  (push_job)
    );

    wcx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    wcx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .busy      (back_busy)
    );

    // An accepted end of string always leaves a job queued
    a_eos_queues_job: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.end_of_string |=> !q_stat.empty)
        else $error("end of string accepted without a queued job");

    // The back end is never mid-expansion with nothing queued
    a_idle_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !back_busy)
        else $error("back end busy while job queue is empty");

    // String completion only on the last word of a run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.string_done |-> out_data.last_of_run)
        else $error("string_done without last_of_run");

endmodule
